// ===== sv/fcfl_pkg.sv =====
// Shared types, codes and constants of the fixed chunk free list allocator.
package fcfl_pkg;

    localparam int NUM_CHUNKS_DEF   = 256;
    localparam int HEADER_BYTES_DEF = 4;

    localparam int ADDR_W  = 21;
    localparam int IDX_W   = 8;
    localparam int LINK_W  = 9;
    localparam int BYTES_W = 13;
    localparam int COUNT_W = 9;
    localparam int STAT_W  = 2;

    localparam logic [BYTES_W-1:0] BYTES_MAX   = 13'd4096;
    localparam logic [BYTES_W-1:0] BYTES_RESET = 13'd64;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd256;
    localparam logic [LINK_W-1:0]  NULL_LINK   = 9'd256;

    typedef enum logic [0:0] {
        REG_CHUNK_BYTES   = 1'b0,
        REG_CHUNKS_IN_USE = 1'b1
    } t_reg_idx;

    typedef enum logic [0:0] {
        KIND_ALLOC = 1'b0,
        KIND_FREE  = 1'b1
    } t_kind;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_EMPTY     = 2'd1,
        STAT_NULL_FREE = 2'd2,
        STAT_BAD_ADDR  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_POP  = 2'd1,
        ST_MUL  = 2'd2,
        ST_DIV  = 2'd3
    } t_state;

    typedef struct packed {
        logic              kind;
        logic [ADDR_W-1:0] free_address;
    } t_cmd;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ADDR_W-1:0] address;
        logic [IDX_W-1:0]  chunk_number;
    } t_res;

endpackage

// ===== sv/fcfl_ram.sv =====
// Generic single write port RAM with registered read.
module fcfl_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/fcfl_div.sv =====
// Restoring divider, one quotient bit per cycle, for offset to chunk index.
module fcfl_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [fcfl_pkg::ADDR_W-1:0]     i_dividend,
    input  logic [fcfl_pkg::BYTES_W-1:0]    i_divisor,
    output logic                            o_done,
    output logic [fcfl_pkg::ADDR_W-1:0]     o_quotient,
    output logic [fcfl_pkg::BYTES_W-1:0]    o_remainder
);

    localparam int CNT_W = $clog2(fcfl_pkg::ADDR_W + 1);

    logic                          r_busy, n_busy;
    logic                          r_done, n_done;
    logic [CNT_W-1:0]              r_count, n_count;
    logic [fcfl_pkg::BYTES_W-1:0]  r_rem, n_rem;
    logic [fcfl_pkg::ADDR_W-1:0]   r_quo, n_quo;
    logic [fcfl_pkg::BYTES_W:0]    w_shift;
    logic [fcfl_pkg::BYTES_W:0]    w_diff;

    assign w_shift = {r_rem, r_quo[fcfl_pkg::ADDR_W-1]};
    assign w_diff  = w_shift - {1'b0, i_divisor};

    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_count = r_count;
        n_rem   = r_rem;
        n_quo   = r_quo;
        if (i_start) begin
            n_busy  = 1'b1;
            n_count = CNT_W'(fcfl_pkg::ADDR_W);
            n_rem   = '0;
            n_quo   = i_dividend;
        end else if (r_busy) begin
            // keep the partial remainder below the divisor
            if (w_shift >= {1'b0, i_divisor}) begin
                n_rem = w_diff[fcfl_pkg::BYTES_W-1:0];
                n_quo = {r_quo[fcfl_pkg::ADDR_W-2:0], 1'b1};
            end else begin
                n_rem = w_shift[fcfl_pkg::BYTES_W-1:0];
                n_quo = {r_quo[fcfl_pkg::ADDR_W-2:0], 1'b0};
            end
            n_count = r_count - 1'b1;
            if (r_count == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_busy  <= n_busy;
            r_done  <= n_done;
            r_count <= n_count;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

// ===== sv/fixed_chunk_free_list_allocator.sv =====
// Fixed chunk pool allocator: freed list in a link RAM plus a fresh chunk counter.
//
// Commands enter on i_cmd when i_start is high and o_busy is low. Each
// command gives exactly one result word on o_res, shown for one cycle with
// o_res_valid; the receiver cannot stall, so the word is taken at that edge.
// An alloc that pops the freed list passes the link RAM read, then the
// index times stride multiply, before its result; one from the fresh
// counter passes only the multiply; a pool empty, null free or short
// address answers in the cycle after it is taken. A free of a real address
// runs the restoring divider, one quotient bit a cycle over 21 bits, and
// answers once the divider is done. o_busy stays high until the result word
// is registered, so the next command may start in the cycle that the result is shown.
// Registers are written through i_cfg_valid/o_cfg_ready (always ready);
// index 0 is the payload size, index 1 the number of chunks. Any write, and
// reset, empties the pool: the freed list is dropped and the fresh counter
// cleared, so chunks come out again in ascending order. Reset also loads
// 64 payload bytes and 256 chunks. Link RAM entries are only read after a
// free has written them, so the RAM needs no clearing.
module fixed_chunk_free_list_allocator #(
    parameter int NUM_CHUNKS   = fcfl_pkg::NUM_CHUNKS_DEF,
    parameter int HEADER_BYTES = fcfl_pkg::HEADER_BYTES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  fcfl_pkg::t_cmd                i_cmd,
    output logic                          o_res_valid,
    output fcfl_pkg::t_res                o_res,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_index,
    input  logic [fcfl_pkg::BYTES_W-1:0]  i_cfg_data
);

    localparam int LIM     = (NUM_CHUNKS < 256) ? NUM_CHUNKS : 256;
    localparam int RAM_AW  = $clog2(LIM);
    localparam logic [fcfl_pkg::COUNT_W-1:0] LIM_N = fcfl_pkg::COUNT_W'(LIM);
    localparam logic [fcfl_pkg::ADDR_W-1:0]  HDR_A = fcfl_pkg::ADDR_W'(HEADER_BYTES);

    fcfl_pkg::t_state              r_state, n_state;
    logic [fcfl_pkg::BYTES_W-1:0]  r_chunk_bytes, n_chunk_bytes;
    logic [fcfl_pkg::COUNT_W-1:0]  r_chunks, n_chunks;
    logic [fcfl_pkg::LINK_W-1:0]   r_head, n_head;
    logic [fcfl_pkg::COUNT_W-1:0]  r_fresh, n_fresh;
    logic [fcfl_pkg::IDX_W-1:0]    r_idx, n_idx;
    logic                          r_res_valid, n_res_valid;
    fcfl_pkg::t_res                r_res, n_res;

    logic [fcfl_pkg::BYTES_W-1:0]  w_eff_bytes;
    logic [fcfl_pkg::BYTES_W-1:0]  w_stride;
    logic [fcfl_pkg::COUNT_W-1:0]  w_eff_n;
    logic [fcfl_pkg::ADDR_W-1:0]   w_prod;
    logic [fcfl_pkg::ADDR_W-1:0]   w_off;
    logic                          w_accept;
    logic                          w_cfg_we;
    logic                          w_div_start;
    logic                          w_div_done;
    logic [fcfl_pkg::ADDR_W-1:0]   w_quo;
    logic [fcfl_pkg::BYTES_W-1:0]  w_rem;
    logic                          w_we;
    logic [fcfl_pkg::LINK_W-1:0]   w_rdata;

    // clamp the configured values into their working ranges
    always_comb begin
        if (r_chunk_bytes == '0) begin
            w_eff_bytes = fcfl_pkg::BYTES_W'(1);
        end else if (r_chunk_bytes > fcfl_pkg::BYTES_MAX) begin
            w_eff_bytes = fcfl_pkg::BYTES_MAX;
        end else begin
            w_eff_bytes = r_chunk_bytes;
        end
        if (r_chunks == '0) begin
            w_eff_n = fcfl_pkg::COUNT_W'(1);
        end else if (r_chunks > LIM_N) begin
            w_eff_n = LIM_N;
        end else begin
            w_eff_n = r_chunks;
        end
    end

    assign w_stride = w_eff_bytes + fcfl_pkg::BYTES_W'(HEADER_BYTES);
    assign w_prod   = fcfl_pkg::ADDR_W'(r_idx) * fcfl_pkg::ADDR_W'(w_stride) + HDR_A;
    assign w_off    = i_cmd.free_address - HDR_A;
    assign w_accept = i_start && !o_busy;
    assign w_cfg_we = i_cfg_valid && o_cfg_ready;

    always_comb begin
        n_state       = r_state;
        n_chunk_bytes = r_chunk_bytes;
        n_chunks      = r_chunks;
        n_head        = r_head;
        n_fresh       = r_fresh;
        n_idx         = r_idx;
        n_res_valid   = 1'b0;
        n_res         = r_res;
        w_div_start   = 1'b0;
        w_we          = 1'b0;

        case (r_state)
            fcfl_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_res = '0;
                    if (i_cmd.kind == fcfl_pkg::KIND_ALLOC) begin
                        if (!r_head[fcfl_pkg::LINK_W-1]) begin
                            n_idx   = r_head[fcfl_pkg::IDX_W-1:0];
                            n_state = fcfl_pkg::ST_POP;
                        end else if (r_fresh < w_eff_n) begin
                            n_idx   = r_fresh[fcfl_pkg::IDX_W-1:0];
                            n_fresh = r_fresh + 1'b1;
                            n_state = fcfl_pkg::ST_MUL;
                        end else begin
                            n_res.status = fcfl_pkg::STAT_EMPTY;
                            n_res_valid  = 1'b1;
                        end
                    end else if (i_cmd.free_address == '0) begin
                        n_res.status = fcfl_pkg::STAT_NULL_FREE;
                        n_res_valid  = 1'b1;
                    end else if (i_cmd.free_address < HDR_A) begin
                        n_res.status = fcfl_pkg::STAT_BAD_ADDR;
                        n_res_valid  = 1'b1;
                    end else begin
                        w_div_start = 1'b1;
                        n_state     = fcfl_pkg::ST_DIV;
                    end
                end
            end
            fcfl_pkg::ST_POP: begin
                // link word of the old head is on the RAM output now
                n_head  = w_rdata;
                n_state = fcfl_pkg::ST_MUL;
            end
            fcfl_pkg::ST_MUL: begin
                n_res.status       = fcfl_pkg::STAT_OK;
                n_res.address      = w_prod;
                n_res.chunk_number = r_idx;
                n_res_valid        = 1'b1;
                n_state            = fcfl_pkg::ST_IDLE;
            end
            fcfl_pkg::ST_DIV: begin
                if (w_div_done) begin
                    n_res_valid = 1'b1;
                    n_state     = fcfl_pkg::ST_IDLE;
                    if (w_rem != '0 || w_quo >= fcfl_pkg::ADDR_W'(w_eff_n)
                        || w_quo >= fcfl_pkg::ADDR_W'(r_fresh)) begin
                        n_res.status = fcfl_pkg::STAT_BAD_ADDR;
                    end else begin
                        w_we               = 1'b1;
                        n_head             = fcfl_pkg::LINK_W'(w_quo[fcfl_pkg::IDX_W-1:0]);
                        n_res.status       = fcfl_pkg::STAT_OK;
                        n_res.chunk_number = w_quo[fcfl_pkg::IDX_W-1:0];
                    end
                end
            end
            default: begin
                n_state = fcfl_pkg::ST_IDLE;
            end
        endcase

        // a register write empties the pool
        if (w_cfg_we) begin
            case (i_cfg_index)
                fcfl_pkg::REG_CHUNK_BYTES:   n_chunk_bytes = i_cfg_data;
                fcfl_pkg::REG_CHUNKS_IN_USE: n_chunks = i_cfg_data[fcfl_pkg::COUNT_W-1:0];
                default: ;
            endcase
            n_head  = fcfl_pkg::NULL_LINK;
            n_fresh = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= fcfl_pkg::ST_IDLE;
            r_chunk_bytes <= fcfl_pkg::BYTES_RESET;
            r_chunks      <= fcfl_pkg::COUNT_RESET;
            r_head        <= fcfl_pkg::NULL_LINK;
            r_fresh       <= '0;
            r_res_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_chunk_bytes <= n_chunk_bytes;
            r_chunks      <= n_chunks;
            r_head        <= n_head;
            r_fresh       <= n_fresh;
            r_res_valid   <= n_res_valid;
        end
        r_idx <= n_idx;
        r_res <= n_res;
    end

    fcfl_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_div_start),
        .i_dividend  (w_off),
        .i_divisor   (w_stride),
        .o_done      (w_div_done),
        .o_quotient  (w_quo),
        .o_remainder (w_rem)
    );

    fcfl_ram #(
        .WIDTH (fcfl_pkg::LINK_W),
        .DEPTH (LIM)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_quo[RAM_AW-1:0]),
        .i_wdata (r_head),
        .i_raddr (r_head[RAM_AW-1:0]),
        .o_rdata (w_rdata)
    );

    assign o_busy      = (r_state != fcfl_pkg::ST_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;
    assign o_cfg_ready = 1'b1;

    a_err_res_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.status != fcfl_pkg::STAT_OK)
            |-> (o_res.address == '0 && o_res.chunk_number == '0))
        else $error("failed result carries address or chunk number");

    a_pop_head : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fcfl_pkg::ST_POP) |-> !r_head[fcfl_pkg::LINK_W-1])
        else $error("pop from an empty freed list");

    a_fresh_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fresh <= w_eff_n)
        else $error("fresh count beyond pool size");

    a_div_owner : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == fcfl_pkg::ST_DIV))
        else $error("divider finished outside a free");

endmodule
